FILE: rtl/spi_msb_pkg.sv
package spi_msb_pkg;

   // Item codes carried in the mode field of an input item.
   typedef enum logic [1:0] {
      MODE_TICK       = 2'd0,
      MODE_WRITE_DATA = 2'd1,
      MODE_READ_DATA  = 2'd2,
      MODE_READ_STAT  = 2'd3
   } mode_type;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int DIV_CFG_W  = 7;
   localparam int BYTE_W     = 8;

   // Register indexes, taken from paddr[3:2].
   typedef enum logic [1:0] {
      REG_CLOCK_DIVIDER = 2'd0,
      REG_IDLE_LEVEL    = 2'd1,
      REG_ENGINE_ENABLE = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_index_type;

   typedef struct packed {
      mode_type          mode;
      logic [BYTE_W-1:0] write_byte;
      logic              miso_bit;
   } req_payload_type;

   typedef struct packed {
      logic              serial_clock;
      logic              mosi_bit;
      logic [BYTE_W-1:0] read_byte;
      logic              busy_flag;
      logic              receive_full;
   } rsp_payload_type;

   // Settings and control from the register block to the shift engine.
   typedef struct packed {
      logic [DIV_CFG_W-1:0] clock_divider;
      logic                 idle_data_level;
      logic                 engine_enable;
      logic                 abort;
   } csr_ctl_type;

endpackage

FILE: rtl/spi_msb_csr.sv
module spi_msb_csr
   import spi_msb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output csr_ctl_type           ctl
);

   logic [DIV_CFG_W-1:0] divider_ff, divider_in;
   logic                 idle_ff, idle_in;
   logic                 enable_ff, enable_in;
   logic                 abort_ff, abort_in;
   logic                 wr_en;
   reg_index_type        index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign index      = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      divider_in = divider_ff;
      idle_in    = idle_ff;
      enable_in  = enable_ff;
      abort_in   = 1'b0;
      if (wr_en) begin
         case (index)
            REG_CLOCK_DIVIDER: divider_in = csr_pwdata[DIV_CFG_W-1:0];
            REG_IDLE_LEVEL:    idle_in    = csr_pwdata[0];
            REG_ENGINE_ENABLE: begin
               enable_in = csr_pwdata[0];
               abort_in  = !csr_pwdata[0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff <= '0;
         idle_ff    <= 1'b0;
         enable_ff  <= 1'b0;
         abort_ff   <= 1'b0;
      end else begin
         divider_ff <= divider_in;
         idle_ff    <= idle_in;
         enable_ff  <= enable_in;
         abort_ff   <= abort_in;
      end
   end

   always_comb begin
      case (index)
         REG_CLOCK_DIVIDER: csr_prdata = CSR_DATA_W'(divider_ff);
         REG_IDLE_LEVEL:    csr_prdata = CSR_DATA_W'(idle_ff);
         REG_ENGINE_ENABLE: csr_prdata = CSR_DATA_W'(enable_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign ctl.clock_divider   = divider_ff;
   assign ctl.idle_data_level = idle_ff;
   assign ctl.engine_enable   = enable_ff;
   assign ctl.abort           = abort_ff;

endmodule

FILE: rtl/spi_msb_core.sv
module spi_msb_core
   import spi_msb_pkg::*;
#(
   parameter int DATA_BITS    = 8,
   parameter int DIVIDER_BITS = 7
)(
   input  logic            clock,
   input  logic            reset,
   input  csr_ctl_type     ctl,
   input  logic            item_en,
   input  req_payload_type item,
   output rsp_payload_type result
);

   localparam int BitW = $clog2(DATA_BITS + 1);

   logic [DIVIDER_BITS-1:0] div_ff, div_in;
   logic [BitW-1:0]         bit_ff, bit_in;
   logic [DATA_BITS-1:0]    shift_ff, shift_in;
   logic [DATA_BITS-1:0]    rx_ff, rx_in;
   logic                    busy_ff, busy_in;
   logic                    full_ff, full_in;
   logic                    phase_ff, phase_in;
   logic                    latch_ff, latch_in;
   logic [31:0]             div_wide;
   logic [DIVIDER_BITS-1:0] div_limit;
   logic [BYTE_W-1:0]       rd_byte;

   assign div_wide  = 32'(ctl.clock_divider);
   assign div_limit = div_wide[DIVIDER_BITS-1:0];

   always_comb begin
      div_in   = div_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      rx_in    = rx_ff;
      busy_in  = busy_ff;
      full_in  = full_ff;
      phase_in = phase_ff;
      latch_in = latch_ff;
      rd_byte  = '0;
      // An abort leaves the engine idle; an item taken in the same cycle still acts,
      // with the engine already disabled.
      if (ctl.abort) begin
         busy_in  = 1'b0;
         phase_in = 1'b0;
         div_in   = '0;
         bit_in   = '0;
         latch_in = 1'b0;
      end
      if (item_en) begin
         case (item.mode)
            MODE_TICK: begin
               if (busy_ff && ctl.engine_enable) begin
                  if (div_ff < div_limit) begin
                     div_in = div_ff + 1'b1;
                  end else begin
                     div_in = '0;
                     if (!phase_ff) begin
                        // Rising edge: sample MISO.
                        phase_in = 1'b1;
                        latch_in = item.miso_bit;
                     end else begin
                        // Falling edge: shift the sampled bit in.
                        phase_in = 1'b0;
                        shift_in = {shift_ff[DATA_BITS-2:0], latch_ff};
                        bit_in   = bit_ff + 1'b1;
                        if (bit_in >= BitW'(DATA_BITS)) begin
                           rx_in    = shift_in;
                           full_in  = 1'b1;
                           busy_in  = 1'b0;
                           div_in   = '0;
                           bit_in   = '0;
                           latch_in = 1'b0;
                        end
                     end
                  end
               end
            end
            MODE_WRITE_DATA: begin
               if (ctl.engine_enable && !busy_ff) begin
                  shift_in = DATA_BITS'(item.write_byte);
                  busy_in  = 1'b1;
                  bit_in   = '0;
                  div_in   = '0;
                  phase_in = 1'b0;
                  latch_in = 1'b0;
               end
            end
            MODE_READ_DATA: begin
               rd_byte = rx_ff[BYTE_W-1:0];
               full_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff   <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         rx_ff    <= '0;
         busy_ff  <= 1'b0;
         full_ff  <= 1'b0;
         phase_ff <= 1'b0;
         latch_ff <= 1'b0;
      end else begin
         div_ff   <= div_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         rx_ff    <= rx_in;
         busy_ff  <= busy_in;
         full_ff  <= full_in;
         phase_ff <= phase_in;
         latch_ff <= latch_in;
      end
   end

   // The result reflects the state after this item.
   assign result.serial_clock = phase_in;
   assign result.mosi_bit     = busy_in ? shift_in[DATA_BITS-1] : ctl.idle_data_level;
   assign result.read_byte    = rd_byte;
   assign result.busy_flag    = busy_in;
   assign result.receive_full = full_in;

endmodule

FILE: rtl/spi_msb_outq.sv
module spi_msb_outq
   import spi_msb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rsp_payload_type push_data,
   output logic            full,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   rsp_payload_type head_ff, head_in;
   rsp_payload_type skid_ff, skid_in;
   logic            head_vld_ff, head_vld_in;
   logic            skid_vld_ff, skid_vld_in;
   logic            pop;

   assign pop = head_vld_ff && !rsp_stall;

   always_comb begin
      head_in     = head_ff;
      skid_in     = skid_ff;
      head_vld_in = head_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (pop) begin
         if (skid_vld_ff) begin
            head_in = skid_ff;
         end else begin
            head_vld_in = 1'b0;
         end
         skid_vld_in = 1'b0;
      end
      if (push) begin
         if (!head_vld_in) begin
            head_in     = push_data;
            head_vld_in = 1'b1;
         end else begin
            skid_in     = push_data;
            skid_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         head_vld_ff <= head_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_vld_ff;
   assign rsp_valid = head_vld_ff;
   assign rsp_data  = head_ff;

endmodule

FILE: rtl/spi_master_byte_shifter_unit.sv
// Channel    | Handshake                     | Payload
// req_       | req_valid / req_stall         | req_data   (mode, write_byte, miso_bit)
// rsp_       | rsp_valid / rsp_stall         | rsp_data   (serial_clock, mosi_bit, read_byte,
//            |                               |             busy_flag, receive_full)
// csr_       | psel / penable / pwrite       | paddr, pwdata, prdata; pready tied high
//
// One item is taken per clock cycle while req_stall is low; its state update and result
// are formed in the cycle of acceptance. Results pass through a two-entry output buffer
// before rsp_ and show once those ahead are taken. req_stall is high from the cycle after
// a result entered the second entry until the waiting head transfer is taken, so each
// stalled rsp_ cycle while results stream costs one stalled cycle on req_.
// Reset is synchronous and clears the shift engine, the CSRs and the buffer's valid flags.
module spi_master_byte_shifter_unit
   import spi_msb_pkg::*;
#(
   parameter int DATA_BITS    = 8,
   parameter int DIVIDER_BITS = 7
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   csr_ctl_type     ctl;
   rsp_payload_type result;
   logic            accept;
   logic            q_full;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   spi_msb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ctl         (ctl)
   );

   spi_msb_core #(
      .DATA_BITS    (DATA_BITS),
      .DIVIDER_BITS (DIVIDER_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .item_en (accept),
      .item    (req_data),
      .result  (result)
   );

   spi_msb_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .full      (q_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/spi_msb_checker.sv
module spi_msb_checker
   import spi_msb_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // The input side only stalls when a result is waiting.
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // With the buffer empty, at most one result can arrive, so no stall follows.
   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |=> !req_stall)
      else $error("input stalled after an empty cycle");

   // The serial clock is low whenever no transfer is running.
   a_idle_clock_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.busy_flag |-> !rsp_data.serial_clock)
      else $error("serial clock high while idle");

endmodule

bind spi_master_byte_shifter_unit spi_msb_checker u_spi_msb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
